// ----- hw/rtl/wcr_pkg.sv -----
// ----------------------------------------------------------------------------
// wcr_pkg
// Shared types and constants of the waveform column renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package wcr_pkg;

    localparam int unsigned COL_W  = 7;
    localparam int unsigned SAMP_W = 6;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PAGE_W = 3;

    localparam logic [PAGE_W-1:0] PAGE_LAST = 3'd7;

    // Four bytes for every page write.
    localparam logic [1:0] PH_PAGE = 2'd0;
    localparam logic [1:0] PH_COLL = 2'd1;
    localparam logic [1:0] PH_COLH = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    localparam logic [BYTE_W-1:0] CMD_PAGE = 8'hb0;
    localparam logic [BYTE_W-1:0] CMD_COLH = 8'h10;
    localparam logic [BYTE_W-1:0] BYTE_ALL = 8'hff;
    localparam logic [BYTE_W-1:0] BYTE_NONE = 8'h00;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic              clear;
        logic [1:0]        phase;
        logic [PAGE_W-1:0] idx;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic at_lo;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/wcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// wcr_ctrl
// Sequencer: steps through the stroke pages and then the eight clearing pages,
// four bytes per page.
// ----------------------------------------------------------------------------
`default_nettype none

module wcr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire wcr_pkg::t_sts i_sts,
    output wcr_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STROKE = 2'd1;
    localparam logic [1:0] S_CLEAR  = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [1:0]                 r_phase, n_phase;
    logic [wcr_pkg::PAGE_W-1:0] r_idx,   n_idx;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;

        o_cmd.load  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.emit  = (r_state != S_IDLE) && i_sts.out_free;
        o_cmd.clear = (r_state == S_CLEAR);
        o_cmd.phase = r_phase;
        o_cmd.idx   = r_idx;
        o_cmd.last  = (r_state == S_CLEAR) && (r_idx == wcr_pkg::PAGE_LAST)
                      && (r_phase == wcr_pkg::PH_DATA);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_STROKE;
                    n_phase = wcr_pkg::PH_PAGE;
                    n_idx   = '0;
                end
            end
            S_STROKE: begin
                if (o_cmd.emit) begin
                    n_phase = r_phase + 2'd1;
                    if (r_phase == wcr_pkg::PH_DATA) begin
                        if (i_sts.at_lo) begin
                            n_state = S_CLEAR;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                end
            end
            S_CLEAR: begin
                if (o_cmd.emit) begin
                    n_phase = r_phase + 2'd1;
                    if (r_phase == wcr_pkg::PH_DATA) begin
                        if (r_idx == wcr_pkg::PAGE_LAST) begin
                            n_state = S_IDLE;
                        end
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= wcr_pkg::PH_PAGE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("byte issued while output register occupied");

    a_load_to_stroke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_STROKE) && (r_idx == '0))
        else $error("sample accepted without starting the stroke");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("final byte issued but sequencer did not return to idle");

    a_data_only_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STROKE && r_phase != wcr_pkg::PH_DATA && o_cmd.emit)
        |=> (r_state == S_STROKE))
        else $error("stroke left before its data byte");

endmodule

`default_nettype wire

// ----- hw/rtl/wcr_dp.sv -----
// ----------------------------------------------------------------------------
// wcr_dp
// Datapath: sample registers, page span and byte generation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wcr_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [wcr_pkg::COL_W-1:0]    i_column,
    input  wire logic [wcr_pkg::SAMP_W-1:0]   i_sample,
    input  wire wcr_pkg::t_cmd                i_cmd,
    output wcr_pkg::t_sts                     o_sts,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [wcr_pkg::BYTE_W-1:0]        o_byte,
    output logic                              o_is_data,
    output logic                              o_last
);

    logic [wcr_pkg::COL_W-1:0]  r_col;
    logic [wcr_pkg::SAMP_W-1:0] r_prev;
    logic [wcr_pkg::SAMP_W-1:0] r_cur;
    logic                       r_valid;
    logic [wcr_pkg::BYTE_W-1:0] r_byte;
    logic                       r_is_data;
    logic                       r_last;

    logic [2:0]                 pb, bb, pc, bc;
    logic [7:0]                 mb, mc;
    logic [2:0]                 hi, lo, page;
    logic [7:0]                 v_top, v_bot, v_same, v_data, col8, n_byte;
    logic [15:0]                sh_bot;

    always_comb begin
        pb = ~r_prev[5:3];
        bb = ~r_prev[2:0];
        pc = ~r_cur[5:3];
        bc = ~r_cur[2:0];
        mb = 8'h01 << bb;
        mc = 8'h01 << bc;
        sh_bot = '0;

        if (bc == bb) begin
            v_same = mc;
        end else if (bc > bb) begin
            v_same = (mc - mb) | mc;
        end else begin
            v_same = mb - mc;
        end

        if (pb > pc) begin
            hi    = pb;
            lo    = pc;
            v_top = mb - 8'h01;
            v_bot = wcr_pkg::BYTE_ALL << bc;
        end else begin
            hi     = pc;
            lo     = pb;
            v_top  = {mc[6:0], 1'b0} - 8'h01;
            sh_bot = {8'h00, wcr_pkg::BYTE_ALL} << ({1'b0, bb} + 4'd1);
            v_bot  = sh_bot[7:0];
        end

        if (i_cmd.clear) begin
            page = i_cmd.idx;
            col8 = {1'b0, r_col} + 8'd1;
        end else begin
            page = hi - i_cmd.idx;
            col8 = {1'b0, r_col};
        end

        if (i_cmd.clear) begin
            v_data = wcr_pkg::BYTE_NONE;
        end else if (hi == lo) begin
            v_data = v_same;
        end else if (page == hi) begin
            v_data = v_top;
        end else if (page == lo) begin
            v_data = v_bot;
        end else begin
            v_data = wcr_pkg::BYTE_ALL;
        end

        case (i_cmd.phase)
            wcr_pkg::PH_PAGE: n_byte = wcr_pkg::CMD_PAGE | {5'd0, page};
            wcr_pkg::PH_COLL: n_byte = {4'd0, col8[3:0]};
            wcr_pkg::PH_COLH: n_byte = wcr_pkg::CMD_COLH | {4'd0, col8[7:4]};
            wcr_pkg::PH_DATA: n_byte = v_data;
            default:          n_byte = v_data;
        endcase
    end

    assign o_sts.out_free = !r_valid || i_ready;
    assign o_sts.at_lo    = (page == lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= 6'd63;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cur <= i_sample;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col  <= i_column;
            r_prev <= r_cur;
        end
        if (i_cmd.emit) begin
            r_byte    <= n_byte;
            r_is_data <= (i_cmd.phase == wcr_pkg::PH_DATA);
            r_last    <= i_cmd.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_is_data = r_is_data;
    assign o_last    = r_last;

endmodule

`default_nettype wire

// ----- hw/rtl/waveform_column_renderer.sv -----
// ----------------------------------------------------------------------------
// waveform_column_renderer
// Turns a stream of (column, sample) pairs into command and pixel bytes for a
// page-addressed 128x64 panel.
// ----------------------------------------------------------------------------
// Input stream: tdata carries the column and the sample. One sample is taken
// in at a time; tready is high only while the block is idle.
// Output stream: tdata carries one panel byte, tuser tells data from command
// and tlast marks the final byte produced for a sample.
// For each sample the block writes the stroke joining the previous sample to
// the current one (one page write per page spanned) and then clears all eight
// pages of the next column. A page write is four bytes, so one sample yields
// (span + 1) * 4 + 32 bytes, 36 to 64. The sequencer emits one byte per cycle
// while the output register is free or being emptied. The first byte is held
// in the output register after the sequencer has entered its stroke state.
// A stalled receiver holds the output register; the sequencer waits and
// resumes when the byte is taken. Reset empties the output register and sets
// the stored sample to 63 (top row of page 0).
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_column_renderer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [6:0] column, [12:7] sample, [15:13] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tuser,   // [0] is_data
    output logic             o_m_tlast
);

    wcr_pkg::t_cmd cmd;
    wcr_pkg::t_sts sts;

    wcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wcr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_column  (i_s_tdata[6:0]),
        .i_sample  (i_s_tdata[12:7]),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_is_data (o_m_tuser),
        .o_last    (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- dv/waveform_column_renderer_tb.sv -----
// ----------------------------------------------------------------------------
// waveform_column_renderer_tb
// Self-checking testbench for the waveform column renderer.
// ----------------------------------------------------------------------------
// Column and sample pairs go in on the input stream. A scoreboard predicts the
// command and pixel bytes of each stroke and of the following clearing pass,
// then checks every output transfer against them in order. A directed set
// covers the stroke cases and the column wrap. Random waveforms then run under
// three idling mixes, with one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_column_renderer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct {
        logic [7:0] pbyte;
        logic       is_data;
        logic       last;
    } t_panel_byte;

    class panel_scoreboard;
        t_panel_byte due_bytes[$];
        logic [5:0]  held_sample;
        int unsigned samples_seen;
        int unsigned bytes_checked;
        int unsigned errors;

        function new();
            held_sample   = 6'd63;
            samples_seen  = 0;
            bytes_checked = 0;
            errors        = 0;
        endfunction

        function void push_byte(logic [7:0] b, logic d);
            t_panel_byte e;
            e.pbyte   = b;
            e.is_data = d;
            e.last    = 1'b0;
            due_bytes.push_back(e);
        endfunction

        function void page_write(int page, logic [7:0] col, int data);
            push_byte(wcr_pkg::CMD_PAGE + 8'(page), 1'b0);
            push_byte({4'h0, col[3:0]}, 1'b0);
            push_byte(wcr_pkg::CMD_COLH | {4'h0, col[7:4]}, 1'b0);
            push_byte(8'(data), 1'b1);
        endfunction

        function void render_sample(logic [6:0] col, logic [5:0] s);
            int pc, bc, mc, pb, bb, mb, v;
            logic [7:0] col8;
            t_panel_byte tail;
            col8 = {1'b0, col};
            pc = 7 - int'(s[5:3]);
            bc = 7 - int'(s[2:0]);
            mc = 1 << bc;
            pb = 7 - int'(held_sample[5:3]);
            bb = 7 - int'(held_sample[2:0]);
            mb = 1 << bb;
            if (pb > pc) begin
                page_write(pb, col8, (mb - 1) & 255);
                for (int p = pb - 1; p > pc; p--) page_write(p, col8, 255);
                page_write(pc, col8, (255 << bc) & 255);
            end else if (pb == pc) begin
                if (bc == bb) v = mc;
                else if (bc > bb) v = (mc - mb) | mc;
                else v = mb - mc;
                page_write(pc, col8, v & 255);
            end else begin
                page_write(pc, col8, ((mc << 1) - 1) & 255);
                for (int p = pc - 1; p > pb; p--) page_write(p, col8, 255);
                page_write(pb, col8, (255 << (bb + 1)) & 255);
            end
            held_sample = s;
            for (int p = 0; p < 8; p++) page_write(p, col8 + 8'd1, 0);
            tail = due_bytes.pop_back();
            tail.last = 1'b1;
            due_bytes.push_back(tail);
            samples_seen++;
        endfunction

        function void check(logic [7:0] b, logic d, logic l);
            t_panel_byte e;
            if (due_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected byte %02h user %b last %b", $time, b, d, l);
                return;
            end
            e = due_bytes.pop_front();
            bytes_checked++;
            if (e.pbyte !== b || e.is_data !== d || e.last !== l) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] byte mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                             $time, e.pbyte, e.is_data, e.last, b, d, l);
            end
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [15:0] i_s_tdata  = 16'h0000;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    panel_scoreboard sb = new();

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    logic [6:0]  next_col = 7'd0;
    logic [5:0]  last_sample = 6'd63;

    waveform_column_renderer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check(o_m_tdata, o_m_tuser, o_m_tlast);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_sample(logic [6:0] col, logic [5:0] s);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, s, col};
        do @(posedge i_clk); while (!o_s_tready);
        sb.render_sample(col, s);
        last_sample = s;
        next_col    = col + 7'd1;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_random(int count);
        logic [6:0] col;
        logic [5:0] s;
        int         step;
        for (int i = 0; i < count; i++) begin
            col = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : next_col;
            if ($urandom_range(1) == 0) begin
                s = 6'($urandom_range(63));
            end else begin
                step = int'($urandom_range(10)) - 5;
                step = int'(last_sample) + step;
                if (step < 0) step = 0;
                if (step > 63) step = 63;
                s = 6'(step);
            end
            send_sample(col, s);
        end
    endtask

    logic [6:0] dir_col[20] = '{7'd0, 7'd127, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
                                7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
                                7'd126, 7'd127, 7'd64};
    logic [5:0] dir_smp[20] = '{6'd0, 6'd63, 6'd63, 6'd62, 6'd56, 6'd63, 6'd56, 6'd0, 6'd63,
                                6'd7, 6'd8, 6'd15, 6'd16, 6'd31, 6'd32, 6'd32, 6'd0,
                                6'd0, 6'd0, 6'd42};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 34;
        recv_idle = 58;
        for (int i = 0; i < 20; i++) send_sample(dir_col[i], dir_smp[i]);
        run_random(150);
        wait_drained();

        send_idle = 58;
        recv_idle = 34;
        run_random(160);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        hold_req  = 400;
        run_random(160);
        wait_drained();

        repeat (70) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0d bytes never arrived", sb.pending());
        end
        $display("Covered %0d samples and %0d panel bytes under three idling mixes,",
                 sb.samples_seen, sb.bytes_checked);
        $display("including a long receiver hold-off; %0d mismatches.", sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- waveform_column_renderer.f -----
hw/rtl/wcr_pkg.sv
hw/rtl/wcr_ctrl.sv
hw/rtl/wcr_dp.sv
hw/rtl/waveform_column_renderer.sv
dv/waveform_column_renderer_tb.sv
